// ===== design/jpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpm_pkg
// shared types and constants for the joystick port mixer
// ----------------------------------------------------------------------------
package jpm_pkg;

    localparam int BUTTONS    = 7;
    localparam int PORTS      = 2;
    localparam int HOLD_W     = 8;
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 72;

    localparam logic [BUTTONS-1:0] ALL_BITS     = 7'h7F;
    localparam logic [BUTTONS-1:0] DIGITAL_BITS = 7'h1F;
    localparam logic [BUTTONS-1:0] FIRE_BITS    = 7'h60;
    localparam int                 FIRE2_IDX    = 5;
    localparam int                 FIRE3_IDX    = 6;
    localparam logic [7:0]         POT_UP       = 8'h80;
    localparam logic [7:0]         POT_DOWN     = 8'h00;

    typedef enum logic [2:0] {
        OP_DIR_P1     = 3'd0,
        OP_MOUSE_P1   = 3'd1,
        OP_PERSISTENT = 3'd2,
        OP_ARM        = 3'd3,
        OP_CANCEL     = 3'd4,
        OP_TICK       = 3'd5,
        OP_RELEASE    = 3'd6,
        OP_REFRESH    = 3'd7
    } op_t;

    typedef logic [BUTTONS-1:0] mask_t;
    typedef logic [HOLD_W-1:0]  hold_t;

endpackage

// ===== design/joystick_port_mixer_with_timed_holds.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_port_mixer_with_timed_holds
// mixes active-low joystick sources for two ports with timed overlay holds
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: button_mask, hold_ticks_packed, mouse_present
//                tuser: opcode, port_select
// m_axis    out  tdata: port lines, pot levels, mouse enables, rest and
//                persistent views
//
// one item per cycle while no result is held or m_axis_tready is high; the result appears in the cycle after acceptance
// the state update and the result register share a single clock edge
// s_axis_tready falls only while a result is held and m_axis_tready is low
// reset sets all masks released and all hold counters to zero
// ----------------------------------------------------------------------------
module joystick_port_mixer_with_timed_holds
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // button_mask[6:0], hold_ticks_packed[62:7], mouse_present[63]
    input  logic [jpm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // opcode[2:0], port_select[3]
    input  logic [jpm_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // port1_lines[4:0], port2_lines[9:5], port1_pot_x[17:10],
    // port1_pot_y[25:18], port2_pot_x[33:26], port2_pot_y[41:34],
    // port1_mouse_enable[42], port2_mouse_enable[43], port1_rest_view[50:44],
    // port2_rest_view[57:51], port1_persistent_view[64:58],
    // port2_persistent_view[71:65]
    output logic [jpm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int NB = jpm_pkg::BUTTONS;
    localparam int NP = jpm_pkg::PORTS;
    localparam int HW = jpm_pkg::HOLD_W;

    jpm_pkg::mask_t dir_reg, dir_next;
    jpm_pkg::mask_t mbtn_reg, mbtn_next;
    jpm_pkg::mask_t pers_reg [NP];
    jpm_pkg::mask_t pers_next [NP];
    jpm_pkg::mask_t ovl_reg [NP];
    jpm_pkg::mask_t ovl_next [NP];
    jpm_pkg::hold_t hold_reg [NP][NB];
    jpm_pkg::hold_t hold_next [NP][NB];

    logic                           out_valid_reg, out_valid_next;
    logic [jpm_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic           accept;
    jpm_pkg::op_t   op;
    logic           port_sel;
    jpm_pkg::mask_t mask_in;
    logic [NB*HW-1:0] holds_in;
    logic           mouse_in;

    jpm_pkg::mask_t port1, port2, rest1;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign op       = jpm_pkg::op_t'(s_axis_tuser[2:0]);
    assign port_sel = s_axis_tuser[3];
    assign mask_in  = s_axis_tdata[NB-1:0];
    assign holds_in = s_axis_tdata[NB+NB*HW-1:NB];
    assign mouse_in = s_axis_tdata[NB+NB*HW];

    // state update for one item
    always_comb
    begin
        dir_next  = dir_reg;
        mbtn_next = mbtn_reg;
        for (int p = 0; p < NP; p++)
        begin
            pers_next[p] = pers_reg[p];
            ovl_next[p]  = ovl_reg[p];
            for (int i = 0; i < NB; i++)
            begin
                hold_next[p][i] = hold_reg[p][i];
            end
        end
        unique case (op)
            jpm_pkg::OP_DIR_P1:
            begin
                dir_next = (mask_in & jpm_pkg::DIGITAL_BITS) | jpm_pkg::FIRE_BITS;
            end
            jpm_pkg::OP_MOUSE_P1:
            begin
                mbtn_next = (mask_in & jpm_pkg::DIGITAL_BITS) | jpm_pkg::FIRE_BITS;
            end
            jpm_pkg::OP_PERSISTENT:
            begin
                pers_next[port_sel] = mask_in;
            end
            jpm_pkg::OP_ARM:
            begin
                for (int i = 0; i < NB; i++)
                begin
                    if (holds_in[i*HW +: HW] != '0)
                    begin
                        hold_next[port_sel][i] = holds_in[i*HW +: HW];
                        ovl_next[port_sel][i]  = mask_in[i];
                    end
                end
            end
            jpm_pkg::OP_CANCEL:
            begin
                for (int i = 0; i < NB; i++)
                begin
                    if (mask_in[i])
                    begin
                        hold_next[port_sel][i] = '0;
                        ovl_next[port_sel][i]  = 1'b1;
                    end
                end
            end
            jpm_pkg::OP_TICK:
            begin
                for (int p = 0; p < NP; p++)
                begin
                    for (int i = 0; i < NB; i++)
                    begin
                        if (hold_reg[p][i] != '0)
                        begin
                            hold_next[p][i] = hold_reg[p][i] - HW'(1);
                            if (hold_reg[p][i] == HW'(1))
                            begin
                                ovl_next[p][i] = 1'b1;
                            end
                        end
                    end
                end
            end
            jpm_pkg::OP_RELEASE:
            begin
                for (int p = 0; p < NP; p++)
                begin
                    pers_next[p] = jpm_pkg::ALL_BITS;
                    ovl_next[p]  = jpm_pkg::ALL_BITS;
                    for (int i = 0; i < NB; i++)
                    begin
                        hold_next[p][i] = '0;
                    end
                end
            end
            jpm_pkg::OP_REFRESH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // result from the updated state
    always_comb
    begin
        rest1 = pers_next[0] & ovl_next[0];
        port1 = dir_next & mbtn_next & rest1;
        port2 = pers_next[1] & ovl_next[1];
        out_data_next = {
            pers_next[1],
            pers_next[0],
            port2,
            rest1,
            (port2 & jpm_pkg::FIRE_BITS) != jpm_pkg::FIRE_BITS,
            mouse_in || ((port1 & jpm_pkg::FIRE_BITS) != jpm_pkg::FIRE_BITS),
            port2[jpm_pkg::FIRE3_IDX] ? jpm_pkg::POT_UP : jpm_pkg::POT_DOWN,
            port2[jpm_pkg::FIRE2_IDX] ? jpm_pkg::POT_UP : jpm_pkg::POT_DOWN,
            port1[jpm_pkg::FIRE3_IDX] ? jpm_pkg::POT_UP : jpm_pkg::POT_DOWN,
            port1[jpm_pkg::FIRE2_IDX] ? jpm_pkg::POT_UP : jpm_pkg::POT_DOWN,
            port2[4:0],
            port1[4:0]
        };
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            dir_reg       <= jpm_pkg::ALL_BITS;
            mbtn_reg      <= jpm_pkg::ALL_BITS;
            for (int p = 0; p < NP; p++)
            begin
                pers_reg[p] <= jpm_pkg::ALL_BITS;
                ovl_reg[p]  <= jpm_pkg::ALL_BITS;
                for (int i = 0; i < NB; i++)
                begin
                    hold_reg[p][i] <= '0;
                end
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                dir_reg  <= dir_next;
                mbtn_reg <= mbtn_next;
                for (int p = 0; p < NP; p++)
                begin
                    pers_reg[p] <= pers_next[p];
                    ovl_reg[p]  <= ovl_next[p];
                    for (int i = 0; i < NB; i++)
                    begin
                        hold_reg[p][i] <= hold_next[p][i];
                    end
                end
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== design/jpm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpm_checker
// port-level checks for the joystick port mixer
// ----------------------------------------------------------------------------
module jpm_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [jpm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // an accepted item always yields a result next cycle
    a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted item gave no result");

    // port 2 lines match the low bits of its rest view
    a_port2_lines: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[9:5] == m_axis_tdata[55:51])
        else $error("port 2 lines disagree with rest view");

    // port 2 pot levels and mouse enable follow fire2 and fire3
    a_port2_pots: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[33:26] == (m_axis_tdata[56] ? jpm_pkg::POT_UP : jpm_pkg::POT_DOWN))
            && (m_axis_tdata[41:34] == (m_axis_tdata[57] ? jpm_pkg::POT_UP : jpm_pkg::POT_DOWN))
            && (m_axis_tdata[43] == !(m_axis_tdata[56] && m_axis_tdata[57])))
        else $error("port 2 pot levels inconsistent");

    // a port 1 line must be low wherever its rest view bit is low
    a_port1_lines: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4:0] & ~m_axis_tdata[48:44]) == 5'd0)
        else $error("port 1 line released while rest view pressed");

endmodule

bind joystick_port_mixer_with_timed_holds jpm_checker u_jpm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
